/* design/tcpoom_pkg.sv */
// Shared types and constants for the TCP option order matcher.
package tcpoom_pkg;

  localparam int SLOT_BITS = 3;
  localparam int NCODES    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int LATENCY   = 4;

  typedef logic [SLOT_BITS-1:0] code_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           grade_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MSS       = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_SACK      = 2'd2,
    REG_TIMESTAMP = 2'd3
  } reg_idx_t;

  localparam code_t RST_MSS       = 3'd2;
  localparam code_t RST_WINDOW    = 3'd3;
  localparam code_t RST_SACK      = 3'd4;
  localparam code_t RST_TIMESTAMP = 3'd5;

  localparam grade_t GRADE_VIOLATED  = 2'd0;
  localparam grade_t GRADE_CONSISTENT = 2'd1;
  localparam grade_t GRADE_IDENTICAL = 2'd2;

endpackage

/* design/tcpoom_locate.sv */
// Finds first and last live slot of every option code in a packed option word.
module tcpoom_locate #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]                                  word,
  output logic [tcpoom_pkg::NCODES-1:0]                         present,
  output logic [tcpoom_pkg::NCODES-1:0][$clog2((WORD_BITS+2)/3)-1:0] first_pos,
  output logic [tcpoom_pkg::NCODES-1:0][$clog2((WORD_BITS+2)/3)-1:0] last_pos
);

  localparam int SLOTS    = (WORD_BITS + tcpoom_pkg::SLOT_BITS - 1) / tcpoom_pkg::SLOT_BITS;
  localparam int PAD_BITS = SLOTS * tcpoom_pkg::SLOT_BITS;
  localparam int POS_W    = $clog2(SLOTS);

  logic [PAD_BITS-1:0] padded;
  logic [SLOTS-1:0]    live;

  // a slot is scanned only while it or a higher bit is set
  always_comb begin
    padded = PAD_BITS'(word);
    for (int s = 0; s < SLOTS; s++) begin
      live[s] = |(padded >> (s * tcpoom_pkg::SLOT_BITS));
    end
  end

  always_comb begin
    for (int c = 0; c < tcpoom_pkg::NCODES; c++) begin
      present[c]   = 1'b0;
      first_pos[c] = '0;
      last_pos[c]  = '0;
      for (int s = 0; s < SLOTS; s++) begin
        if (live[s] &&
            padded[s*tcpoom_pkg::SLOT_BITS +: tcpoom_pkg::SLOT_BITS] ==
              tcpoom_pkg::code_t'(c)) begin
          if (!present[c]) begin
            first_pos[c] = POS_W'(s);
          end
          last_pos[c] = POS_W'(s);
          present[c]  = 1'b1;
        end
      end
    end
  end

endmodule

/* design/tcp_option_order_match.sv */
// Top level: pipelined TCP option order matcher.
// Result strobe (done) is the taken start beat carried through s0_valid, s1_valid, s2_valid and done.
// Throughput: one beat per cycle; busy stays low, start may be held high.
// Stages: input register, code location, pairwise order compare, grade.
// Synchronous active-high reset empties the pipeline and reloads the four
// option codes to 2, 3, 4 and 5; the receiver cannot stall results.
module tcp_option_order_match #(
  parameter int WORD_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [WORD_BITS-1:0]         target_options,
  input  logic [WORD_BITS-1:0]         signature_options,
  output logic                         done,
  output logic [1:0]                   match_grade,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcpoom_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [2:0]                   cfg_data
);

  localparam int SLOTS = (WORD_BITS + tcpoom_pkg::SLOT_BITS - 1) / tcpoom_pkg::SLOT_BITS;
  localparam int POS_W = $clog2(SLOTS);
  localparam int NC    = tcpoom_pkg::NCODES;

  typedef logic [NC-1:0][POS_W-1:0] pos_vec_t;

  tcpoom_pkg::code_t code_mss, code_window, code_sack, code_timestamp;

  // stage 0: captured beat
  logic                 s0_valid;
  logic [WORD_BITS-1:0] s0_tar, s0_sig;

  // stage 1: code locations
  logic                 s1_valid, s1_equal;
  logic [NC-1:0]        s1_tar_present, s1_sig_present;
  pos_vec_t             s1_tar_first, s1_tar_last, s1_sig_first;

  // stage 2: order violations per code pair
  logic                 s2_valid, s2_equal;
  logic [NC*NC-1:0]     s2_viol;

  logic [NC-1:0]        tar_present, sig_present;
  pos_vec_t             tar_first, tar_last, sig_first, sig_last;
  logic [NC-1:0]        important;
  logic [NC*NC-1:0]     viol_next;
  tcpoom_pkg::grade_t   grade_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_mss       <= tcpoom_pkg::RST_MSS;
      code_window    <= tcpoom_pkg::RST_WINDOW;
      code_sack      <= tcpoom_pkg::RST_SACK;
      code_timestamp <= tcpoom_pkg::RST_TIMESTAMP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcpoom_pkg::reg_idx_t'(cfg_index))
        tcpoom_pkg::REG_MSS:       code_mss       <= cfg_data;
        tcpoom_pkg::REG_WINDOW:    code_window    <= cfg_data;
        tcpoom_pkg::REG_SACK:      code_sack      <= cfg_data;
        tcpoom_pkg::REG_TIMESTAMP: code_timestamp <= cfg_data;
        default: ;
      endcase
    end
  end

  tcpoom_locate #(.WORD_BITS(WORD_BITS)) u_locate_tar (
    .word      (s0_tar),
    .present   (tar_present),
    .first_pos (tar_first),
    .last_pos  (tar_last)
  );

  tcpoom_locate #(.WORD_BITS(WORD_BITS)) u_locate_sig (
    .word      (s0_sig),
    .present   (sig_present),
    .first_pos (sig_first),
    .last_pos  (sig_last)
  );

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      important[c] = (tcpoom_pkg::code_t'(c) == code_mss)    ||
                     (tcpoom_pkg::code_t'(c) == code_window) ||
                     (tcpoom_pkg::code_t'(c) == code_sack)   ||
                     (tcpoom_pkg::code_t'(c) == code_timestamp);
    end
  end

  // code a seen before code b in target, yet found later in signature
  always_comb begin
    for (int a = 0; a < NC; a++) begin
      for (int b = 0; b < NC; b++) begin
        viol_next[a*NC+b] = s1_tar_present[a] && s1_tar_present[b] &&
                            s1_sig_present[a] && s1_sig_present[b] &&
                            important[a] && important[b] &&
                            (s1_tar_first[a] < s1_tar_last[b]) &&
                            (s1_sig_first[a] > s1_sig_first[b]);
      end
    end
  end

  always_comb begin
    if (s2_equal) begin
      grade_next = tcpoom_pkg::GRADE_IDENTICAL;
    end else if (|s2_viol) begin
      grade_next = tcpoom_pkg::GRADE_VIOLATED;
    end else begin
      grade_next = tcpoom_pkg::GRADE_CONSISTENT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_tar         <= target_options;
    s0_sig         <= signature_options;
    s1_equal       <= (s0_tar == s0_sig);
    s1_tar_present <= tar_present;
    s1_sig_present <= sig_present;
    s1_tar_first   <= tar_first;
    s1_tar_last    <= tar_last;
    s1_sig_first   <= sig_first;
    s2_equal       <= s1_equal;
    s2_viol        <= viol_next;
    match_grade    <= grade_next;
  end

  // last positions of the signature are not needed
  logic unused_sig_last;
  assign unused_sig_last = ^sig_last;

endmodule

/* design/tcpoom_checker.sv */
// Port-level checker for the TCP option order matcher, with its bind.
module tcpoom_checker #(
  parameter int WORD_BITS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [WORD_BITS-1:0] target_options,
  input logic [WORD_BITS-1:0] signature_options,
  input logic                 done,
  input logic [1:0]           match_grade
);

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(tcpoom_pkg::LATENCY) done)
    else $error("beat taken without result strobe");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, tcpoom_pkg::LATENCY))
    else $error("result strobe without a beat");

  a_identical_grade: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && target_options == signature_options)
      |-> ##(tcpoom_pkg::LATENCY) (match_grade == tcpoom_pkg::GRADE_IDENTICAL))
    else $error("identical words not graded identical");

  a_differ_grade: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && target_options != signature_options)
      |-> ##(tcpoom_pkg::LATENCY) (match_grade == tcpoom_pkg::GRADE_VIOLATED ||
                                   match_grade == tcpoom_pkg::GRADE_CONSISTENT))
    else $error("differing words graded identical");

endmodule

bind tcp_option_order_match tcpoom_checker #(.WORD_BITS(WORD_BITS)) u_tcpoom_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .target_options    (target_options),
  .signature_options (signature_options),
  .done              (done),
  .match_grade       (match_grade)
);

/* test/tb.sv */
// Self-checking testbench for the TCP option order matcher: directed table, then random beats.
module tb;

  localparam int WORD_W      = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int BEATS_PHASE = 125;
  localparam int NPHASES     = 6;

  typedef struct {
    logic [WORD_W-1:0]  tar;
    logic [WORD_W-1:0]  sig;
    bit                 typed;
    tcpoom_pkg::grade_t want;
  } dir_row_t;

  typedef struct {
    logic [WORD_W-1:0]  tar;
    logic [WORD_W-1:0]  sig;
    tcpoom_pkg::grade_t want;
  } pending_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [WORD_W-1:0] target_options;
  logic [WORD_W-1:0] signature_options;
  logic              done;
  logic [1:0]        match_grade;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [tcpoom_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [2:0]        cfg_data;

  tcpoom_pkg::code_t key_codes [4];
  pending_t          grades_due [$];
  pending_t          got_item;
  int                errors = 0;
  int                stall_cycles = 0;
  int                beat_count = 0;

  // default codes: 2 mss, 3 window, 4 sack, 5 timestamp
  dir_row_t dir_rows [14] = '{
    '{64'h0, 64'h0, 1'b1, tcpoom_pkg::GRADE_IDENTICAL},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, tcpoom_pkg::GRADE_IDENTICAL},
    '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'h1A, 64'h13, 1'b1, tcpoom_pkg::GRADE_VIOLATED},
    '{64'h1A, 64'h1DA, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'h1A, 64'h03, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},   // mss absent from signature
    '{64'h12, 64'h02, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},   // same code in two slots
    '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'hB1A, 64'h4E5, 1'b1, tcpoom_pkg::GRADE_VIOLATED},
    '{64'hB1A, 64'h58D0, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'h7, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, tcpoom_pkg::GRADE_CONSISTENT},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h2, 1'b0, tcpoom_pkg::GRADE_CONSISTENT}
  };

  tcpoom_pkg::code_t phase_codes [NPHASES][4] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd7, 3'd7, 3'd7, 3'd7},
    '{3'd0, 3'd1, 3'd6, 3'd7},
    '{3'd6, 3'd6, 3'd1, 3'd1},
    '{3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd0, 3'd5, 3'd2, 3'd4}
  };

  tcp_option_order_match #(.WORD_BITS(WORD_W)) u_top (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .target_options    (target_options),
    .signature_options (signature_options),
    .done              (done),
    .match_grade       (match_grade),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_key(tcpoom_pkg::code_t c);
    return c == key_codes[0] || c == key_codes[1] || c == key_codes[2] || c == key_codes[3];
  endfunction

  function automatic tcpoom_pkg::grade_t order_grade(logic [WORD_W-1:0] tar,
                                                     logic [WORD_W-1:0] sig);
    int                last;
    int                pos;
    int                slot;
    tcpoom_pkg::code_t c;
    logic [WORD_W-1:0] s;
    last = -1;
    if (tar == sig) return tcpoom_pkg::GRADE_IDENTICAL;
    while (tar != '0) begin
      c   = tar[tcpoom_pkg::SLOT_BITS-1:0];
      tar = tar >> tcpoom_pkg::SLOT_BITS;
      if (is_key(c)) begin
        pos  = -1;
        slot = 0;
        s    = sig;
        while (s != '0 && pos < 0) begin
          if (s[tcpoom_pkg::SLOT_BITS-1:0] == c) pos = slot;
          s = s >> tcpoom_pkg::SLOT_BITS;
          slot++;
        end
        if (pos >= 0) begin
          if (pos < last) return tcpoom_pkg::GRADE_VIOLATED;
          last = pos;
        end
      end
    end
    return tcpoom_pkg::GRADE_CONSISTENT;
  endfunction

  // option list biased towards the configured codes, mostly short
  function automatic logic [WORD_W-1:0] option_list();
    logic [WORD_W-1:0] w;
    int                len;
    tcpoom_pkg::code_t c;
    w   = '0;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 22) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 70) c = key_codes[$urandom_range(0, 3)];
      else c = tcpoom_pkg::code_t'($urandom_range(0, 7));
      if (i == 21) w[63] = c[0];
      else w[i*tcpoom_pkg::SLOT_BITS +: tcpoom_pkg::SLOT_BITS] = c;
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // caller stands at a rising edge; returns at the edge that takes the beat
  task automatic send_beat(logic [WORD_W-1:0] tar, logic [WORD_W-1:0] sig);
    while ((beat_count < 300 || beat_count >= 420) && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    target_options    <= tar;
    signature_options <= sig;
    @(posedge clk);
    while (busy) @(posedge clk);
    beat_count++;
  endtask

  task automatic write_reg(tcpoom_pkg::reg_idx_t idx, tcpoom_pkg::code_t val);
    while ($urandom_range(0, 99) < 11) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_codes[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (grades_due.size() != 0) @(posedge clk);
    repeat (tcpoom_pkg::LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (grades_due.size() == 0) begin
        report_mismatch($sformatf("grade %0d with no beat pending", match_grade));
      end else begin
        got_item = grades_due.pop_front();
        if (match_grade !== got_item.want)
          report_mismatch($sformatf("tar %h sig %h: grade %0d, want %0d",
                                    got_item.tar, got_item.sig, match_grade, got_item.want));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tcp_option_order_match regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [WORD_W-1:0] tar;
    logic [WORD_W-1:0] sig;
    logic [2:0]        tmp;
    int                kind;
    int                a;
    int                b;
    rst               = 1'b1;
    start             = 1'b0;
    target_options    = '0;
    signature_options = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    key_codes         = '{tcpoom_pkg::RST_MSS, tcpoom_pkg::RST_WINDOW,
                          tcpoom_pkg::RST_SACK, tcpoom_pkg::RST_TIMESTAMP};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].tar, dir_rows[i].sig);
      grades_due.push_back('{dir_rows[i].tar, dir_rows[i].sig,
                             dir_rows[i].typed ? dir_rows[i].want
                                               : order_grade(dir_rows[i].tar, dir_rows[i].sig)});
    end
    start <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NPHASES; p++) begin
      wait_idle();
      if (p == NPHASES - 1)
        for (int k = 0; k < 4; k++) phase_codes[p][k] = tcpoom_pkg::code_t'($urandom_range(0, 7));
      write_reg(tcpoom_pkg::REG_MSS,       phase_codes[p][0]);
      write_reg(tcpoom_pkg::REG_WINDOW,    phase_codes[p][1]);
      write_reg(tcpoom_pkg::REG_SACK,      phase_codes[p][2]);
      write_reg(tcpoom_pkg::REG_TIMESTAMP, phase_codes[p][3]);
      for (int n = 0; n < BEATS_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        tar  = option_list();
        if (kind < 10) begin
          sig = tar;
        end else if (kind < 40) begin
          // swapped pair of slots: likely order violation
          sig = tar;
          a   = $urandom_range(0, 7);
          b   = (a + $urandom_range(1, 7)) % 8;
          tmp = sig[a*tcpoom_pkg::SLOT_BITS +: tcpoom_pkg::SLOT_BITS];
          sig[a*tcpoom_pkg::SLOT_BITS +: tcpoom_pkg::SLOT_BITS] =
            sig[b*tcpoom_pkg::SLOT_BITS +: tcpoom_pkg::SLOT_BITS];
          sig[b*tcpoom_pkg::SLOT_BITS +: tcpoom_pkg::SLOT_BITS] = tmp;
        end else if (kind < 80) begin
          sig = option_list();
        end else if (kind < 90) begin
          tar = {$urandom, $urandom};
          sig = {$urandom, $urandom};
        end else begin
          tar = {$urandom, $urandom};
          sig = tar ^ (64'h1 << $urandom_range(0, 63));
        end
        send_beat(tar, sig);
        grades_due.push_back('{tar, sig, order_grade(tar, sig)});
      end
      start <= 1'b0;
      @(posedge clk);
    end

    wait_idle();
    if (errors == 0) begin
      $display("tcp_option_order_match regression: pass");
    end else begin
      $display("tcp_option_order_match regression: fail");
    end
    $finish;
  end

endmodule
